// ===== rtl/core/bsli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded step line interpolator package
// Shared word types, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package bsli_pkg;

	localparam int MAX_STEPS = 64;
	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int REG_W     = 21;
	localparam int TW_W      = 8;
	localparam int RUN_W     = 9;
	localparam int IDX_W     = 7;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_STEP       = 3'd0,
		REG_FINAL_MAX_STEP = 3'd1,
		REG_MIN_DISTANCE   = 3'd2,
		REG_FORM_OFFSET    = 3'd3,
		REG_TOTAL_WAYPTS   = 3'd4
	} cfg_reg_t;

	localparam logic [REG_W-1:0] MAX_STEP_RST    = 21'd22938;
	localparam logic [REG_W-1:0] FINAL_STEP_RST  = 21'd6554;
	localparam logic [REG_W-1:0] MIN_DIST_RST    = 21'd6554;
	localparam logic [REG_W-1:0] FORM_OFFSET_RST = 21'd26214;
	localparam logic [TW_W-1:0]  TOTAL_WPT_RST   = 8'd22;

	typedef struct packed {
		logic signed [POS_W-1:0] cur_x;
		logic signed [POS_W-1:0] cur_y;
		logic signed [POS_W-1:0] cur_z;
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic signed [POS_W-1:0] goal_z;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x_minus;
		logic signed [POS_W-1:0] x_plus;
		logic signed [POS_W-1:0] y_minus;
		logic signed [POS_W-1:0] y_plus;
		logic signed [POS_W-1:0] z_out;
		logic [IDX_W-1:0]        step_index;
		logic                    last;
		logic                    clamped;
	} pt_t;

endpackage

// ===== rtl/core/bsli_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded step line interpolator channels
// Valid/ready channels for request words and formation point words.
// ----------------------------------------------------------------------------
interface bsli_req_if;
	logic           valid;
	logic           ready;
	bsli_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bsli_pt_if;
	logic          valid;
	logic          ready;
	bsli_pkg::pt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bounded_step_line_interpolator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded step line interpolator core
// Splits a 3-D move into bounded steps and spreads each point to a square
// formation, using bit-serial square, root and division units.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                       Handshake
// req       in   cur and goal points        valid/ready
// pt        out  formation point, index     valid/ready
// cfg       in   register index and data    write enable only
//
// A request goes through serial squaring, root, ceiling division and step
// division, then emits one point per cycle while the output is free, unless the
// move is below the minimum distance or the run count is past the waypoint limit.
// One request is in work at a time; ready is high only while idle.
// The output register lets a new request enter while the last point waits.
// Reset clears the run counter and loads the register defaults.
// ----------------------------------------------------------------------------
module bounded_step_line_interpolator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	bsli_req_if.sink                          req,
	bsli_pt_if.source                         pt,
	input  logic                              cfg_we,
	input  logic [bsli_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [bsli_pkg::REG_W-1:0]        cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_CHK, ST_DIVC, ST_NSEL, ST_DIVN, ST_EMIT
	} state_t;

	localparam int PW = bsli_pkg::POS_W;
	localparam int RW = bsli_pkg::REG_W;
	localparam int IW = bsli_pkg::IDX_W;

	state_t state_q;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;
	logic [bsli_pkg::RUN_W-1:0] run_q;
	logic [RW-1:0] max_step_q, final_step_q, min_dist_q, offset_q;
	logic [bsli_pkg::TW_W-1:0] tw_q;
	logic pt_valid_q, emit_ok_q, clamp_q;
	logic [IW-1:0] n_q, idx_q;

	logic signed [PW-1:0] cur_q [3];
	logic [2:0] neg_q;
	logic [PW:0] mag_q [3];
	logic [PW:0] m_q;
	logic [65:0] mcand_q;
	logic [PW:0] mplier_q;
	logic [67:0] acc_q;
	logic [33:0] root_q;
	logic [36:0] rem_q;
	logic [RW-1:0] lim_q;
	logic [33:0] num_q, cq_q;
	logic [RW:0] drem_q;
	logic [PW:0] dv_q [3];
	logic [PW:0] qa_q [3];
	logic [IW-1:0] ra_q [3];
	logic [PW:0] qs_q [3];
	logic [IW-1:0] rs_q [3];
	bsli_pkg::pt_t pt_q;

	logic req_acc, emit_fire;
	logic signed [PW:0] d_in [3];
	logic [PW:0] mag_in [3];
	logic [PW:0] m_in;
	logic [36:0] rem_sh;
	logic [35:0] trial;
	logic root_ge;
	logic [RW:0] dtry;
	logic dge;
	logic [RW-1:0] lim_sel;
	logic [17:0] fl;
	logic [IW-1:0] n_sel;
	logic clamp_sel;
	logic [PW:0] qs_n [3];
	logic [IW-1:0] rs_n [3];
	logic [IW:0] dq_t [3];
	logic dq_ge [3];
	logic signed [33:0] p_s [3];
	logic signed [33:0] pm_x, pp_x, pm_y, pp_y;
	logic [IW-1:0] idx_n;

	function automatic logic signed [PW-1:0] sat32(input logic signed [33:0] v);
		logic signed [PW-1:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign pt.valid  = pt_valid_q;
	assign pt.data   = pt_q;
	assign emit_fire = (state_q == ST_EMIT) && (!pt_valid_q || pt.ready);

	always_comb begin
		d_in[0] = {req.data.goal_x[PW-1], req.data.goal_x} - {req.data.cur_x[PW-1], req.data.cur_x};
		d_in[1] = {req.data.goal_y[PW-1], req.data.goal_y} - {req.data.cur_y[PW-1], req.data.cur_y};
		d_in[2] = {req.data.goal_z[PW-1], req.data.goal_z} - {req.data.cur_z[PW-1], req.data.cur_z};
		for (int a = 0; a < 3; a++) begin
			mag_in[a] = d_in[a][PW] ? (PW+1)'(0) - d_in[a] : d_in[a];
		end
		m_in = mag_in[0];
		if (mag_in[1] > m_in) begin
			m_in = mag_in[1];
		end
		if (mag_in[2] > m_in) begin
			m_in = mag_in[2];
		end
	end

	always_comb begin
		rem_sh  = {rem_q[34:0], acc_q[67:66]};
		trial   = {root_q, 2'b01};
		root_ge = rem_sh >= {1'b0, trial};
		dtry    = {drem_q[RW-1:0], num_q[33]};
		dge     = dtry >= {1'b0, lim_q};
		lim_sel = (({1'b0, run_q} + 10'd2) > {2'b00, tw_q}) ? final_step_q : max_step_q;
		if (lim_sel == '0) begin
			lim_sel = RW'(1);
		end
		fl = root_q[33:bsli_pkg::FRAC_BITS];
		clamp_sel = (fl > 18'(bsli_pkg::MAX_STEPS)) || (cq_q > 34'(bsli_pkg::MAX_STEPS));
		if (clamp_sel) begin
			n_sel = IW'(bsli_pkg::MAX_STEPS);
		end else begin
			n_sel = IW'(1);
			if (fl[IW-1:0] > n_sel) begin
				n_sel = fl[IW-1:0];
			end
			if (cq_q[IW-1:0] > n_sel) begin
				n_sel = cq_q[IW-1:0];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dq_t[a]  = {ra_q[a], dv_q[a][PW]};
			dq_ge[a] = dq_t[a] >= {1'b0, n_q};
		end
	end

	always_comb begin
		logic [IW:0] rsum;
		logic c;
		for (int a = 0; a < 3; a++) begin
			rsum = {1'b0, rs_q[a]} + {1'b0, ra_q[a]};
			c = rsum >= {1'b0, n_q};
			rs_n[a] = c ? IW'(rsum - {1'b0, n_q}) : rsum[IW-1:0];
			qs_n[a] = qs_q[a] + qa_q[a] + {{PW{1'b0}}, c};
			p_s[a] = {{2{cur_q[a][PW-1]}}, cur_q[a]}
				+ (neg_q[a] ? 34'sd0 - $signed({1'b0, qs_n[a]}) : $signed({1'b0, qs_n[a]}));
		end
		pm_x  = p_s[0] - $signed({13'd0, offset_q});
		pp_x  = p_s[0] + $signed({13'd0, offset_q});
		pm_y  = p_s[1] - $signed({13'd0, offset_q});
		pp_y  = p_s[1] + $signed({13'd0, offset_q});
		idx_n = idx_q + IW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			axis_q       <= '0;
			run_q        <= '0;
			max_step_q   <= bsli_pkg::MAX_STEP_RST;
			final_step_q <= bsli_pkg::FINAL_STEP_RST;
			min_dist_q   <= bsli_pkg::MIN_DIST_RST;
			offset_q     <= bsli_pkg::FORM_OFFSET_RST;
			tw_q         <= bsli_pkg::TOTAL_WPT_RST;
			pt_valid_q   <= 1'b0;
			emit_ok_q    <= 1'b0;
			clamp_q      <= 1'b0;
			n_q          <= IW'(1);
			idx_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					bsli_pkg::REG_MAX_STEP:       max_step_q <= cfg_wdata;
					bsli_pkg::REG_FINAL_MAX_STEP: final_step_q <= cfg_wdata;
					bsli_pkg::REG_MIN_DISTANCE:   min_dist_q <= cfg_wdata;
					bsli_pkg::REG_FORM_OFFSET:    offset_q <= cfg_wdata;
					bsli_pkg::REG_TOTAL_WAYPTS:   tw_q <= cfg_wdata[bsli_pkg::TW_W-1:0];
					default: ;
				endcase
			end
			if (emit_fire) begin
				pt_valid_q <= 1'b1;
			end else if (pt.ready) begin
				pt_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_SQ;
						cnt_q   <= '0;
						axis_q  <= '0;
					end
				end
				ST_SQ: begin
					if (cnt_q == 6'd32) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= ST_ROOT;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd33) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					cnt_q <= '0;
					if (root_q < {13'd0, min_dist_q}) begin
						state_q <= ST_IDLE;
					end else begin
						state_q   <= ST_DIVC;
						emit_ok_q <= {1'b0, run_q} <= ({2'b00, tw_q} + 10'd1);
						if (run_q != '1) begin
							run_q <= run_q + 9'd1;
						end
					end
				end
				ST_DIVC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd33) begin
						state_q <= ST_NSEL;
					end
				end
				ST_NSEL: begin
					n_q     <= n_sel;
					clamp_q <= clamp_sel;
					cnt_q   <= '0;
					state_q <= ST_DIVN;
				end
				ST_DIVN: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						idx_q   <= '0;
						state_q <= emit_ok_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						idx_q <= idx_n;
						if (idx_n == n_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cur_q[0] <= req.data.cur_x;
			cur_q[1] <= req.data.cur_y;
			cur_q[2] <= req.data.cur_z;
			for (int a = 0; a < 3; a++) begin
				neg_q[a] <= d_in[a][PW];
				mag_q[a] <= mag_in[a];
			end
			m_q      <= m_in;
			mcand_q  <= {33'd0, mag_in[0]};
			mplier_q <= mag_in[0];
			acc_q    <= '0;
			root_q   <= '0;
			rem_q    <= '0;
		end
		if (state_q == ST_SQ) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + {2'b00, mcand_q};
			end
			if (cnt_q == 6'd32) begin
				mcand_q  <= {33'd0, (axis_q == 2'd0) ? mag_q[1] : mag_q[2]};
				mplier_q <= (axis_q == 2'd0) ? mag_q[1] : mag_q[2];
			end else begin
				mcand_q  <= {mcand_q[64:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[PW:1]};
			end
		end
		if (state_q == ST_ROOT) begin
			acc_q  <= {acc_q[65:0], 2'b00};
			root_q <= {root_q[32:0], root_ge};
			rem_q  <= root_ge ? rem_sh - {1'b0, trial} : rem_sh;
		end
		if (state_q == ST_CHK) begin
			lim_q  <= lim_sel;
			num_q  <= {1'b0, m_q} + {13'd0, lim_sel} - 34'd1;
			drem_q <= '0;
			cq_q   <= '0;
		end
		if (state_q == ST_DIVC) begin
			drem_q <= dge ? dtry - {1'b0, lim_q} : dtry;
			num_q  <= {num_q[32:0], 1'b0};
			cq_q   <= {cq_q[32:0], dge};
		end
		if (state_q == ST_NSEL) begin
			for (int a = 0; a < 3; a++) begin
				dv_q[a] <= mag_q[a];
				ra_q[a] <= '0;
				qa_q[a] <= '0;
			end
		end
		if (state_q == ST_DIVN) begin
			for (int a = 0; a < 3; a++) begin
				ra_q[a] <= dq_ge[a] ? IW'(dq_t[a] - {1'b0, n_q}) : dq_t[a][IW-1:0];
				dv_q[a] <= {dv_q[a][PW-1:0], 1'b0};
				qa_q[a] <= {qa_q[a][PW-1:0], dq_ge[a]};
				qs_q[a] <= '0;
				rs_q[a] <= '0;
			end
		end
		if (emit_fire) begin
			for (int a = 0; a < 3; a++) begin
				qs_q[a] <= qs_n[a];
				rs_q[a] <= rs_n[a];
			end
			pt_q.x_minus    <= sat32(pm_x);
			pt_q.x_plus     <= sat32(pp_x);
			pt_q.y_minus    <= sat32(pm_y);
			pt_q.y_plus     <= sat32(pp_y);
			pt_q.z_out      <= sat32(p_s[2]);
			pt_q.step_index <= idx_n;
			pt_q.last       <= (idx_n == n_q);
			pt_q.clamped    <= clamp_q;
		end
	end

endmodule

// ===== rtl/core/bsli_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded step line interpolator checker
// Port-level checks on the request and point channels.
// ----------------------------------------------------------------------------
module bsli_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_ready,
	input logic                          pt_valid,
	input logic                          pt_ready,
	input bsli_pkg::pt_t                 pt_data
);

	// A held point word must not change.
	a_pt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_ready |=> pt_valid && $stable(pt_data))
		else $error("point word changed while stalled");

	// While a run is still emitting, no new request is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_data.last |-> !req_ready)
		else $error("request ready during a run");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid |-> pt_data.step_index != '0 &&
			pt_data.step_index <= bsli_pkg::IDX_W'(bsli_pkg::MAX_STEPS))
		else $error("step index out of range");

	// A clamped run always ends on the largest step count.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_data.clamped && pt_data.last |->
			pt_data.step_index == bsli_pkg::IDX_W'(bsli_pkg::MAX_STEPS))
		else $error("clamped run ended early");

endmodule

bind bounded_step_line_interpolator_core bsli_chk u_bsli_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.pt_valid  (pt.valid),
	.pt_ready  (pt.ready),
	.pt_data   (pt.data)
);

// ===== verif/bounded_step_line_interpolator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded step line interpolator core testbench
// Drives move requests through the request channel, splits each move into
// formation points with a local predictor and checks every point word that
// leaves the block. Runs through several register settings and idling phases.
// ----------------------------------------------------------------------------
module bounded_step_line_interpolator_core_tb;
	import bsli_pkg::*;

	localparam int LAT_CYC = 400;
	localparam int WDOG_LIM = 6000;
	localparam int RAND_PER_PHASE = 86;

	typedef struct {
		req_t mv;
		bit   typed;
		bit   has_pt;
		pt_t  pt;
	} row_t;

	typedef struct {
		logic [REG_W-1:0] step;
		logic [REG_W-1:0] fstep;
		logic [REG_W-1:0] mind;
		logic [REG_W-1:0] offs;
		logic [TW_W-1:0]  twp;
		int               src_idle;
		int               snk_stall;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0] cfg_wdata;

	bsli_req_if req_ch ();
	bsli_pt_if  pt_ch ();

	bounded_step_line_interpolator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.pt        (pt_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	logic [REG_W-1:0] m_step, m_fstep, m_mind, m_offs;
	logic [TW_W-1:0]  m_twp;
	int unsigned      m_runs;
	pt_t              pending_pts[$];
	int               n_err;
	int               idle_pct;
	int               stall_pct;
	int               quiet_cyc;

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = ~clk;
	end

	function automatic logic [POS_W-1:0] sat32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] root_floor(logic [69:0] v);
		logic [71:0] rem;
		logic [71:0] trial;
		logic [63:0] rt;
		rem = '0;
		rt = '0;
		for (int k = 34; k >= 0; k--) begin
			rem = (rem << 2) | 72'((v >> (2 * k)) & 70'd3);
			trial = (72'(rt) << 2) | 72'd1;
			rt = rt << 1;
			if (rem >= trial) begin
				rem = rem - trial;
				rt = rt | 64'd1;
			end
		end
		return rt;
	endfunction

	// Splits a move into points and, if not below the minimum distance, advances the run count.
	function automatic void split_move(req_t mv, ref pt_t pts[$]);
		longint c[3], d[3];
		logic [63:0] mg[3];
		logic [63:0] big, lim, n, cq, q, root_d;
		logic [69:0] sq_sum;
		longint p[3];
		bit clp;
		pt_t o;
		pts.delete();
		c[0] = longint'(mv.cur_x);
		c[1] = longint'(mv.cur_y);
		c[2] = longint'(mv.cur_z);
		d[0] = longint'(mv.goal_x) - c[0];
		d[1] = longint'(mv.goal_y) - c[1];
		d[2] = longint'(mv.goal_z) - c[2];
		big = 0;
		sq_sum = 0;
		for (int a = 0; a < 3; a++) begin
			mg[a] = d[a] < 0 ? 64'(-d[a]) : 64'(d[a]);
			if (mg[a] > big) begin
				big = mg[a];
			end
			sq_sum = sq_sum + 70'(mg[a] * mg[a]);
		end
		root_d = root_floor(sq_sum);
		if (root_d < 64'(m_mind)) begin
			return;
		end
		lim = (int'(m_runs) + 2 > int'(m_twp)) ? 64'(m_fstep) : 64'(m_step);
		if (lim == 0) begin
			lim = 1;
		end
		n = 1;
		if ((root_d >> FRAC_BITS) > n) begin
			n = root_d >> FRAC_BITS;
		end
		cq = (big + lim - 1) / lim;
		if (cq > n) begin
			n = cq;
		end
		clp = 1'b0;
		if (n > MAX_STEPS) begin
			n = MAX_STEPS;
			clp = 1'b1;
		end
		if (int'(m_runs) <= int'(m_twp) + 1) begin
			for (int i = 1; i <= int'(n); i++) begin
				for (int a = 0; a < 3; a++) begin
					q = (mg[a] * 64'(i)) / n;
					p[a] = d[a] < 0 ? c[a] - longint'(q) : c[a] + longint'(q);
				end
				o.x_minus = sat32(p[0] - longint'(m_offs));
				o.x_plus = sat32(p[0] + longint'(m_offs));
				o.y_minus = sat32(p[1] - longint'(m_offs));
				o.y_plus = sat32(p[1] + longint'(m_offs));
				o.z_out = sat32(p[2]);
				o.step_index = IDX_W'(i);
				o.last = (i == int'(n));
				o.clamped = clp;
				pts.push_back(o);
			end
		end
		if (m_runs < 511) begin
			m_runs++;
		end
	endfunction

	function automatic pt_t mk_pt(int xm, int xp, int ym, int yp, int z);
		pt_t o;
		o.x_minus = xm;
		o.x_plus = xp;
		o.y_minus = ym;
		o.y_plus = yp;
		o.z_out = z;
		o.step_index = 1;
		o.last = 1'b1;
		o.clamped = 1'b0;
		return o;
	endfunction

	function automatic req_t mk_mv(int cx, int cy, int cz, int gx, int gy, int gz);
		req_t r;
		r.cur_x = cx;
		r.cur_y = cy;
		r.cur_z = cz;
		r.goal_x = gx;
		r.goal_y = gy;
		r.goal_z = gz;
		return r;
	endfunction

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Most moves are hops of three spans; the rest are null, edge-valued or fully random long moves.
	function automatic req_t rand_move();
		req_t r;
		int roll;
		int span;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 80) begin
			span = roll < 58 ? 19 : (roll < 70 ? 12 : 21);
			r.goal_x = r.cur_x + ($signed($urandom) >>> (31 - span));
			r.goal_y = r.cur_y + ($signed($urandom) >>> (31 - span));
			r.goal_z = r.cur_z + ($signed($urandom) >>> (31 - span));
		end else if (roll < 86) begin
			r.goal_x = r.cur_x;
			r.goal_y = r.cur_y;
			r.goal_z = r.cur_z;
		end else if (roll < 94) begin
			r = {pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge()};
		end
		return r;
	endfunction

	task automatic cfg_write(cfg_reg_t idx, logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_MAX_STEP: m_step = val;
			REG_FINAL_MAX_STEP: m_fstep = val;
			REG_MIN_DISTANCE: m_mind = val;
			REG_FORM_OFFSET: m_offs = val;
			REG_TOTAL_WAYPTS: m_twp = val[TW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_phase(phase_t ph);
		cfg_write(REG_MAX_STEP, ph.step);
		cfg_write(REG_FINAL_MAX_STEP, ph.fstep);
		cfg_write(REG_MIN_DISTANCE, ph.mind);
		cfg_write(REG_FORM_OFFSET, ph.offs);
		cfg_write(REG_TOTAL_WAYPTS, REG_W'(ph.twp));
		cfg_we <= 1'b0;
		idle_pct = ph.src_idle;
		stall_pct = ph.snk_stall;
	endtask

	task automatic send_move(req_t mv, bit typed, bit has_pt, pt_t tp);
		pt_t pts[$];
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= mv;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		split_move(mv, pts);
		if (typed) begin
			pts.delete();
			if (has_pt) begin
				pts.push_back(tp);
			end
		end
		foreach (pts[k]) begin
			pending_pts.push_back(pts[k]);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		wait (pending_pts.size() == 0);
		repeat (LAT_CYC) @(posedge clk);
	endtask

	always @(posedge clk) begin
		pt_t want;
		if (pt_ch.valid && pt_ch.ready) begin
			if (pending_pts.size() == 0) begin
				n_err++;
				if (n_err <= 10) begin
					$display("unexpected point word %h", pt_ch.data);
				end
			end else begin
				want = pending_pts.pop_front();
				if (pt_ch.data !== want) begin
					n_err++;
					if (n_err <= 10) begin
						$display("point mismatch: expected %h got %h", want, pt_ch.data);
					end
				end
			end
		end
		pt_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (pt_ch.valid && pt_ch.ready)) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= WDOG_LIM) begin
			$display("bounded_step_line_interpolator_core regression: fail");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	initial begin
		row_t rows[$];
		phase_t phases[$];
		pt_t none;
		none = '0;
		n_err = 0;
		quiet_cyc = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_MAX_STEP;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		pt_ch.ready = 1'b0;
		m_step = MAX_STEP_RST;
		m_fstep = FINAL_STEP_RST;
		m_mind = MIN_DIST_RST;
		m_offs = FORM_OFFSET_RST;
		m_twp = TOTAL_WPT_RST;
		m_runs = 0;

		rows.push_back('{mk_mv(0, 0, 0, 16384, 0, 0), 1, 1,
			mk_pt(-9830, 42598, -26214, 26214, 0)});
		rows.push_back('{mk_mv(0, 0, 0, 0, 0, 6554), 1, 1,
			mk_pt(-26214, 26214, -26214, 26214, 6554)});
		rows.push_back('{mk_mv(0, 0, 0, 0, 0, 6553), 1, 0, none});
		rows.push_back('{mk_mv(32'h12345678, -5, 77, 32'h12345678, -5, 77), 1, 0, none});
		rows.push_back('{mk_mv(0, 0, 0, 0, 0, 0), 1, 0, none});
		rows.push_back('{mk_mv(0, 0, 0, -65536, 131072, -300000), 0, 0, none});
		rows.push_back('{mk_mv(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff), 0, 0, none});
		rows.push_back('{mk_mv(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0, 0, none});
		rows.push_back('{mk_mv(32'sh7fff_c000, 32'sh8000_4000, 5, 32'sh7fff_ffff,
			32'sh8000_0000, 5), 0, 0, none});
		rows.push_back('{mk_mv(-1, -1, -1, 200000, -200000, 3), 0, 0, none});
		rows.push_back('{mk_mv(100, 100, 0, 100, 100, 32'sh0080_0000), 0, 0, none});
		rows.push_back('{mk_mv(7, 8, 9, 7 + 22938, 8, 9), 0, 0, none});
		rows.push_back('{mk_mv(7, 8, 9, 7 + 22939, 8, 9), 0, 0, none});

		phases.push_back('{MAX_STEP_RST, FINAL_STEP_RST, MIN_DIST_RST, FORM_OFFSET_RST,
			8'd255, 0, 0});
		phases.push_back('{21'd1048576, 21'd1, 21'd0, 21'd1048576, 8'd255, 70, 0});
		phases.push_back('{21'd1, 21'd1048576, 21'd0, 21'd0, 8'd255, 0, 70});
		phases.push_back('{21'd0, 21'd0, 21'd1048576, 21'd1000, 8'd2, 13, 13});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			send_move(rows[k].mv, rows[k].typed, rows[k].has_pt, rows[k].pt);
		end
		drain();

		foreach (phases[ph]) begin
			load_phase(phases[ph]);
			repeat (RAND_PER_PHASE) send_move(rand_move(), 0, 0, none);
			drain();
		end

		if (n_err == 0 && pending_pts.size() == 0) begin
			$display("bounded_step_line_interpolator_core regression: pass");
		end else begin
			$display("bounded_step_line_interpolator_core regression: fail");
		end
		$finish;
	end

endmodule

// ===== bounded_step_line_interpolator_core.f =====
rtl/core/bsli_pkg.sv
rtl/core/bsli_if.sv
rtl/core/bounded_step_line_interpolator_core.sv
rtl/core/bsli_chk.sv
verif/bounded_step_line_interpolator_core_tb.sv
